@@ hdl/assert_macros.svh @@
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clock edge, muted while reset is held
`define IMSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every rising clock edge, reset included
`define IMSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hdl/imsc_pkg.sv @@
// shared constants and codes of the ir mark/space capture block
`default_nettype none

package imsc_pkg;

  localparam int unsigned TOP_W   = 16;
  localparam int unsigned HUND_W  = 5;
  localparam int unsigned DIGIT_W = 4;

  localparam logic [TOP_W-1:0] TOP_RESET = 16'hFFFF;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_EDGE = 1'b1
  } imsc_op_t;

endpackage

`default_nettype wire

@@ hdl/imsc_if.sv @@
// handshake channels of the ir mark/space capture block
`default_nettype none

interface imsc_in_if;
  logic valid;
  logic ready;
  logic opcode;
  logic pin_level;

  modport source(output valid, opcode, pin_level, input ready);
  modport sink(input valid, opcode, pin_level, output ready);
endinterface

interface imsc_out_if;
  import imsc_pkg::*;
  logic               valid;
  logic               ready;
  logic [HUND_W-1:0]  mark_hundreds;
  logic [DIGIT_W-1:0] mark_tens;
  logic [DIGIT_W-1:0] mark_ones;
  logic [HUND_W-1:0]  space_hundreds;
  logic [DIGIT_W-1:0] space_tens;
  logic [DIGIT_W-1:0] space_ones;

  modport source(output valid, mark_hundreds, mark_tens, mark_ones,
                 space_hundreds, space_tens, space_ones, input ready);
  modport sink(input valid, mark_hundreds, mark_tens, mark_ones,
               space_hundreds, space_tens, space_ones, output ready);
endinterface

interface imsc_cfg_if;
  import imsc_pkg::*;
  logic             valid;
  logic             ready;
  logic [TOP_W-1:0] count_top;

  modport source(output valid, count_top, input ready);
  modport sink(input valid, count_top, output ready);
endinterface

`default_nettype wire

@@ hdl/imsc_digits.sv @@
// three stage pipeline that turns mark and space counts into decimal digits of count/40
`default_nettype none

module imsc_digits #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [COUNT_WIDTH-1:0] in_mark,
  input  wire logic [COUNT_WIDTH-1:0] in_space,
  imsc_out_if.source                  out_ch
);
  import imsc_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned CW   = COUNT_WIDTH;
  localparam int unsigned SH   = CW + 3;
  localparam int unsigned PW   = 2 * CW + 4;
  localparam logic [63:0] POW  = 64'd1 << SH;
  // ceil(2^SH / 5) is exact for any dividend below 2^CW
  localparam logic [CW:0] M5   = (CW + 1)'((POW + 64'd4) / 64'd5);

  function automatic logic [CW-1:0] div5(input logic [CW-1:0] x);
    logic [PW-1:0] p;
    p = PW'(x) * PW'(M5);
    return p[SH +: CW];
  endfunction

  function automatic logic [CW-1:0] times10(input logic [CW-1:0] x);
    return (x << 3) + (x << 1);
  endfunction

  // stage 0: value / 40
  logic          v0_r;
  logic [CW-1:0] u_mark_r, u_space_r;
  // stage 1: split off ones digit
  logic               v1_r;
  logic [CW-1:0]      q_mark_r, q_space_r;
  logic [DIGIT_W-1:0] ones_mark_r, ones_space_r;
  // stage 2: result register
  logic               v2_r;
  logic [HUND_W-1:0]  hund_mark_r, hund_space_r;
  logic [DIGIT_W-1:0] tens_mark_r, tens_space_r;
  logic [DIGIT_W-1:0] ones2_mark_r, ones2_space_r;

  logic rdy0, rdy1, rdy2;
  logic [CW-1:0] q_mark_nxt, q_space_nxt, h_mark_nxt, h_space_nxt;

  assign rdy2     = !v2_r || out_ch.ready;
  assign rdy1     = !v1_r || rdy2;
  assign rdy0     = !v0_r || rdy1;
  assign in_ready = rdy0;

  assign q_mark_nxt  = div5(u_mark_r >> 1);
  assign q_space_nxt = div5(u_space_r >> 1);
  assign h_mark_nxt  = div5(q_mark_r >> 1);
  assign h_space_nxt = div5(q_space_r >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy0) v0_r <= in_valid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && in_valid) begin
      u_mark_r  <= div5(in_mark >> 3);
      u_space_r <= div5(in_space >> 3);
    end
    if (rdy1 && v0_r) begin
      q_mark_r     <= q_mark_nxt;
      q_space_r    <= q_space_nxt;
      ones_mark_r  <= DIGIT_W'(u_mark_r - times10(q_mark_nxt));
      ones_space_r <= DIGIT_W'(u_space_r - times10(q_space_nxt));
    end
    if (rdy2 && v1_r) begin
      hund_mark_r   <= HUND_W'(h_mark_nxt);
      hund_space_r  <= HUND_W'(h_space_nxt);
      tens_mark_r   <= DIGIT_W'(q_mark_r - times10(h_mark_nxt));
      tens_space_r  <= DIGIT_W'(q_space_r - times10(h_space_nxt));
      ones2_mark_r  <= ones_mark_r;
      ones2_space_r <= ones_space_r;
    end
  end

  assign out_ch.valid          = v2_r;
  assign out_ch.mark_hundreds  = hund_mark_r;
  assign out_ch.mark_tens      = tens_mark_r;
  assign out_ch.mark_ones      = ones2_mark_r;
  assign out_ch.space_hundreds = hund_space_r;
  assign out_ch.space_tens     = tens_space_r;
  assign out_ch.space_ones     = ones2_space_r;

  `IMSC_ASSERT(a_digits_decimal, v2_r |-> (tens_mark_r <= 4'd9 && ones2_mark_r <= 4'd9 && tens_space_r <= 4'd9 && ones2_space_r <= 4'd9), "digit above nine")
  `IMSC_ASSERT(a_stage1_advance, (v0_r && rdy1) |=> v1_r, "stage 0 item lost")
  `IMSC_ASSERT_ALWAYS(a_empty_takes, !v0_r |-> in_ready, "empty pipeline refuses item")

endmodule

`default_nettype wire

@@ hdl/ir_mark_space_capture_top.sv @@
// top level of the ir mark/space capture block: tick counter, mark store and digit pipeline
//
//  channel | dir | handshake        | payload
//  in_ch   | in  | valid / ready    | opcode, pin_level
//  out_ch  | out | valid / ready    | mark and space hundreds, tens, ones
//  cfg_ch  | in  | valid / ready    | count_top (always ready)
//
// one item per clock while in_ready is high; counter and mark update in the cycle the item is taken
// a result passes through stage 0, 1 and 2 of the three stage digit pipeline and waits while out_ch stalls
// the two reciprocal multipliers of each pipeline stage set the clock path
// in_ready drops only while all three digit stages are full and out_ch stalls
// synchronous reset clears counter, mark and pipeline and loads count_top 65535
`default_nettype none

module ir_mark_space_capture_top #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  imsc_in_if.sink   in_ch,
  imsc_out_if.source out_ch,
  imsc_cfg_if.sink  cfg_ch
);
  import imsc_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned CW   = COUNT_WIDTH;
  localparam int unsigned CMPW = (CW + 1 > TOP_W) ? CW + 1 : TOP_W;

  logic [TOP_W-1:0] count_top_r;
  logic [CW-1:0]    elapsed_count_r, elapsed_count_nxt;
  logic [CW-1:0]    stored_mark_r, stored_mark_nxt;
  logic [CMPW-1:0]  next_ext;
  logic [CW-1:0]    emit_space;
  logic             emit;
  logic             dig_ready;
  logic             in_fire;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = dig_ready;
  assign in_fire      = in_ch.valid && dig_ready;
  assign next_ext     = CMPW'(elapsed_count_r) + CMPW'(1);

  always_comb begin
    elapsed_count_nxt = elapsed_count_r;
    stored_mark_nxt   = stored_mark_r;
    emit_space        = '0;
    emit              = 1'b0;
    if (in_fire) begin
      case (imsc_op_t'(in_ch.opcode))
        OP_TICK: begin
          if (next_ext >= CMPW'(count_top_r)) begin
            // timeout: report a pending mark with no space
            elapsed_count_nxt = '0;
            if (stored_mark_r != '0) begin
              emit            = 1'b1;
              stored_mark_nxt = '0;
            end
          end else begin
            elapsed_count_nxt = next_ext[CW-1:0];
          end
        end
        OP_EDGE: begin
          elapsed_count_nxt = '0;
          if (in_ch.pin_level) begin
            stored_mark_nxt = elapsed_count_r;
          end else if (stored_mark_r != '0) begin
            emit       = 1'b1;
            emit_space = elapsed_count_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_top_r     <= TOP_RESET;
      elapsed_count_r <= '0;
      stored_mark_r   <= '0;
    end else begin
      if (cfg_ch.valid) count_top_r <= cfg_ch.count_top;
      elapsed_count_r <= elapsed_count_nxt;
      stored_mark_r   <= stored_mark_nxt;
    end
  end

  imsc_digits #(
    .COUNT_WIDTH(CW)
  ) u_digits (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(emit),
    .in_ready(dig_ready),
    .in_mark (stored_mark_r),
    .in_space(emit_space),
    .out_ch  (out_ch)
  );

  `IMSC_ASSERT(a_emit_has_mark, emit |-> (stored_mark_r != '0), "result without stored mark")
  `IMSC_ASSERT(a_rise_stores, (in_fire && in_ch.opcode == OP_EDGE && in_ch.pin_level) |=> (stored_mark_r == $past(elapsed_count_r)), "rising edge lost count")
  `IMSC_ASSERT(a_timeout_clears, (emit && in_ch.opcode == OP_TICK) |=> (stored_mark_r == '0 && elapsed_count_r == '0), "timeout left state")

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// self-checking testbench for the ir mark/space capture block: ticks, edges, timeouts, count_top
`timescale 1ns / 1ps

module testbench;
  import imsc_pkg::*;

  localparam int unsigned CNT_W      = 16;
  localparam int unsigned UNIT_TICKS = 40;
  localparam int unsigned DRAIN_WAIT = 8;

  typedef enum int {
    GAP_NONE,
    GAP_SEND,
    GAP_RECV,
    GAP_BOTH
  } gap_mode_t;

  typedef struct packed {
    logic [HUND_W-1:0]  hund;
    logic [DIGIT_W-1:0] tens;
    logic [DIGIT_W-1:0] ones;
  } digits_t;

  typedef struct packed {
    digits_t mark;
    digits_t space;
  } report_t;

  typedef struct {
    imsc_op_t op;
    logic     level;
  } pin_event_t;

  bit   clk;
  logic rst_n;

  imsc_in_if  in_ch();
  imsc_out_if out_ch();
  imsc_cfg_if cfg_ch();

  ir_mark_space_capture_top #(
    .COUNT_WIDTH(CNT_W)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model of the capture state
  logic [TOP_W-1:0] top_model = TOP_RESET;
  logic [CNT_W-1:0] elapsed_ticks = '0;
  logic [CNT_W-1:0] mark_ticks = '0;

  pin_event_t event_q[$];
  report_t    reports_due[$];
  gap_mode_t  gap_mode = GAP_NONE;
  bit         in_fire;
  int         events_queued;
  int         events_taken;
  int         top_writes;
  int         mismatches;

  function automatic digits_t to_digits(input logic [CNT_W-1:0] ticks);
    int unsigned units;
    digits_t     d;
    units  = ticks / UNIT_TICKS;
    d.ones = DIGIT_W'(units % 10);
    d.tens = DIGIT_W'((units / 10) % 10);
    d.hund = HUND_W'(units / 100);
    return d;
  endfunction

  function automatic void measure_item(input imsc_op_t op, input logic level);
    logic [CNT_W:0] next;
    report_t        rep;
    if (op == OP_TICK) begin
      next = {1'b0, elapsed_ticks} + (CNT_W + 1)'(1);
      if (next >= {1'b0, top_model}) begin
        // timeout: a stored mark goes out with a zero space and is forgotten
        elapsed_ticks = '0;
        if (mark_ticks != '0) begin
          rep.mark  = to_digits(mark_ticks);
          rep.space = to_digits('0);
          reports_due.push_back(rep);
          mark_ticks = '0;
        end
      end else begin
        elapsed_ticks = next[CNT_W-1:0];
      end
    end else begin
      if (level) begin
        mark_ticks = elapsed_ticks;
      end else if (mark_ticks != '0) begin
        rep.mark  = to_digits(mark_ticks);
        rep.space = to_digits(elapsed_ticks);
        reports_due.push_back(rep);
      end
      elapsed_ticks = '0;
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic int send_idle_pct();
    return (gap_mode == GAP_SEND) ? 80 : (gap_mode == GAP_BOTH) ? 23 : 0;
  endfunction

  function automatic int recv_stall_pct();
    return (gap_mode == GAP_RECV) ? 80 : (gap_mode == GAP_BOTH) ? 23 : 0;
  endfunction

  // driver: new item at the falling edge once the previous one was taken
  always @(negedge clk) begin : drive
    pin_event_t nxt;
    if (!in_ch.valid || in_fire) begin
      if (event_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
        nxt = event_q.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.opcode    <= nxt.op;
        in_ch.pin_level <= nxt.level;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct());
  end

  // monitor: results checked before the item of this edge is predicted
  always @(posedge clk) begin : watch
    report_t got;
    report_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.mark  = '{out_ch.mark_hundreds, out_ch.mark_tens, out_ch.mark_ones};
        got.space = '{out_ch.space_hundreds, out_ch.space_tens, out_ch.space_ones};
        if (reports_due.size() == 0) begin
          $error("result with nothing expected: mark %0d/%0d/%0d space %0d/%0d/%0d",
                 got.mark.hund, got.mark.tens, got.mark.ones,
                 got.space.hund, got.space.tens, got.space.ones);
          mismatches++;
        end else begin
          want = reports_due.pop_front();
          check_field("mark_hundreds", want.mark.hund, got.mark.hund);
          check_field("mark_tens", want.mark.tens, got.mark.tens);
          check_field("mark_ones", want.mark.ones, got.mark.ones);
          check_field("space_hundreds", want.space.hund, got.space.hund);
          check_field("space_tens", want.space.tens, got.space.tens);
          check_field("space_ones", want.space.ones, got.space.ones);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        top_model = cfg_ch.count_top;
        top_writes++;
      end
      if (in_ch.valid && in_ch.ready) begin
        measure_item(imsc_op_t'(in_ch.opcode), in_ch.pin_level);
        events_taken++;
      end
      in_fire <= in_ch.valid && in_ch.ready;
    end else begin
      in_fire <= 1'b0;
    end
  end

  task automatic push_ticks(input int n);
    pin_event_t e;
    repeat (n) begin
      e.op    = OP_TICK;
      e.level = 1'($urandom_range(0, 1));
      event_q.push_back(e);
      events_queued++;
    end
  endtask

  task automatic push_edge(input logic level);
    pin_event_t e;
    e.op    = OP_EDGE;
    e.level = level;
    event_q.push_back(e);
    events_queued++;
  endtask

  task automatic drain();
    while (events_taken != events_queued || reports_due.size() != 0) @(negedge clk);
    // a result that no item was expected to give may still be in the digit pipeline
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_top(input logic [TOP_W-1:0] value);
    int seen;
    seen = top_writes;
    @(negedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.count_top <= value;
    while (top_writes == seen) @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic int tick_run();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return $urandom_range(1, 12);
    if (p < 95) return $urandom_range(13, 60);
    return $urandom_range(200, 450);
  endfunction

  // mostly rise/fall pairs around tick runs, the rest stray edges and random items
  task automatic random_pulses(input int min_items, input int min_pairs);
    int start;
    int pairs;
    int r;
    start = events_queued;
    pairs = 0;
    while (events_queued - start < min_items || pairs < min_pairs) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        push_ticks(tick_run());
        push_edge(1'b1);
        push_ticks(tick_run());
        push_edge(1'b0);
        pairs++;
      end else if (r < 90) begin
        push_edge(1'($urandom_range(0, 1)));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 1)) push_ticks(1);
          else push_edge(1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  logic [TOP_W-1:0] phase_top[8] = '{16'd40, 16'd65535, 16'd300, 16'd2,
                                     16'd1000, 16'd120, 16'd65534, 16'd60};

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = OP_TICK;
    in_ch.pin_level  = 1'b0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.count_top = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_top(TOP_RESET);
    events_queued += 2;
    event_q.push_back('{OP_TICK, 1'b1});
    event_q.push_back('{OP_TICK, 1'b0});
    // edges with no mark stored report nothing
    push_edge(1'b0);
    push_edge(1'b1);
    push_edge(1'b0);
    push_ticks(45);
    push_edge(1'b1);
    push_ticks(39);
    push_edge(1'b0);
    // mark is kept after a fall, then wiped by a rise right after it
    push_edge(1'b0);
    push_edge(1'b1);
    push_edge(1'b0);
    drain();

    // zero top: every tick wraps, so the rise stores a zero mark and the fall reports nothing
    write_top('0);
    push_ticks(3);
    push_edge(1'b1);
    push_edge(1'b0);
    drain();
    write_top(16'd1);
    push_ticks(2);
    push_edge(1'b1);
    push_ticks(1);
    push_edge(1'b0);
    drain();

    for (int k = 0; k < 8; k++) begin
      write_top(phase_top[k]);
      gap_mode = gap_mode_t'(k % 4);
      random_pulses(100, 2);
      if (k == 2) begin
        // sender holds off until every pending result is out
        drain();
        random_pulses(100, 2);
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/imsc_pkg.sv
hdl/imsc_if.sv
hdl/imsc_digits.sv
hdl/ir_mark_space_capture_top.sv
tb/testbench.sv
